// ===== design/intel_hex_record_parser_macros.svh =====
// Assertion macros for the Intel HEX record parser checker.
// Expects clk and rst_n in the scope of each use.
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

// Check a property while out of reset.
`define IHEX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ihex parser check failed");

// Check a property at every edge, reset included.
`define IHEX_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ihex parser reset check failed");

`endif

// ===== design/ihex_pkg.sv =====
// Shared types, constants and the digit rule of the Intel HEX parser.
// No dependencies.
package ihex_pkg;

  localparam logic [7:0] CHAR_COLON       = 8'h3A;
  localparam logic [7:0] DIGIT_SPLIT      = 8'h40;
  localparam logic [7:0] DIGIT_BASE_NUM   = 8'h30;
  localparam logic [7:0] DIGIT_BASE_ALPHA = 8'd55;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       colon;
    logic [7:0] data;
  } ev_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] address;
    logic [7:0]  record_type;
    logic [7:0]  byte_index;
    logic [7:0]  byte_count;
    logic [7:0]  checksum_value;
    logic        checksum_ok;
  } res_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c < DIGIT_SPLIT) begin
      return c - DIGIT_BASE_NUM;
    end
    return c - DIGIT_BASE_ALPHA;
  endfunction

endpackage

// ===== design/ihex_front.sv =====
// Front end: colon detection, digit decode and nibble pairing into byte events.
// Depends on ihex_pkg.
module ihex_front import ihex_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic [7:0] in_char,
  output logic       ev_push,
  output ev_t        ev
);

  logic       pending_r, pending_nxt;
  logic [3:0] high_r, high_nxt;
  logic [7:0] d;
  logic       is_colon;

  assign is_colon = (in_char == CHAR_COLON);
  assign d        = digit_value(in_char);

  always_comb begin
    pending_nxt = pending_r;
    high_nxt    = high_r;
    ev_push     = 1'b0;
    ev.colon    = is_colon;
    ev.data     = {high_r, 4'h0} + d;
    if (in_accept) begin
      if (is_colon) begin
        pending_nxt = 1'b0;
        ev_push     = 1'b1;
      end else if (pending_r) begin
        pending_nxt = 1'b0;
        ev_push     = 1'b1;
      end else begin
        pending_nxt = 1'b1;
        high_nxt    = d[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      high_r    <= 4'h0;
    end else begin
      pending_r <= pending_nxt;
      high_r    <= high_nxt;
    end
  end

endmodule

// ===== design/ihex_evq.sv =====
// Two-entry event queue between front and back end.
// Depends on ihex_pkg.
module ihex_evq import ihex_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ev_t  push_ev,
  output logic full,
  input  logic pop,
  output logic empty,
  output ev_t  head
);

  ev_t        mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_ev;
    end
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_pop) begin
        rptr_r <= !rptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== design/ihex_back.sv =====
// Back end: record field sequencing, checksum and the two-entry result queue.
// Depends on ihex_pkg.
module ihex_back import ihex_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic ev_empty,
  input  ev_t  ev,
  output logic ev_pop,
  output logic res_empty,
  input  logic res_pop,
  output res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_ADDRH, PH_ADDRL, PH_TYPE, PH_DATA, PH_CHECK
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  offset_r, offset_nxt;
  logic [7:0]  sum_add;

  res_t        q_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  count_r;
  logic        res_push, do_res_pop;
  res_t        new_res;

  assign ev_pop     = !ev_empty && (count_r != 2'd2);
  assign res_empty  = (count_r == 2'd0);
  assign do_res_pop = res_pop && !res_empty;
  assign res        = q_r[rptr_r];
  assign sum_add    = sum_r + ev.data;

  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    left_nxt   = left_r;
    addr_nxt   = addr_r;
    type_nxt   = type_r;
    sum_nxt    = sum_r;
    offset_nxt = offset_r;
    res_push   = 1'b0;
    new_res.kind           = KIND_DATA;
    new_res.data_byte      = ev.data;
    new_res.address        = addr_r + {8'h00, offset_r};
    new_res.record_type    = type_r;
    new_res.byte_index     = offset_r;
    new_res.byte_count     = length_r;
    new_res.checksum_value = 8'h00;
    new_res.checksum_ok    = 1'b0;
    if (ev_pop) begin
      if (ev.colon) begin
        phase_nxt  = PH_COUNT;
        sum_nxt    = 8'h00;
        offset_nxt = 8'h00;
        left_nxt   = 8'h00;
      end else if (phase_r != PH_IDLE) begin
        sum_nxt = sum_add;
        unique case (phase_r)
          PH_COUNT: begin
            length_nxt = ev.data;
            left_nxt   = ev.data;
            phase_nxt  = PH_ADDRH;
          end
          PH_ADDRH: begin
            addr_nxt  = {ev.data, 8'h00};
            phase_nxt = PH_ADDRL;
          end
          PH_ADDRL: begin
            addr_nxt  = {addr_r[15:8], ev.data};
            phase_nxt = PH_TYPE;
          end
          PH_TYPE: begin
            type_nxt   = ev.data;
            offset_nxt = 8'h00;
            phase_nxt  = (left_r != 8'h00) ? PH_DATA : PH_CHECK;
          end
          PH_DATA: begin
            res_push   = 1'b1;
            offset_nxt = offset_r + 8'd1;
            left_nxt   = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            res_push               = 1'b1;
            new_res.kind           = KIND_END;
            new_res.data_byte      = 8'h00;
            new_res.address        = addr_r;
            new_res.byte_index     = 8'h00;
            new_res.checksum_value = ev.data;
            new_res.checksum_ok    = (sum_add == 8'h00);
            phase_nxt              = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wptr_r] <= new_res;
    end
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      length_r <= 8'h00;
      left_r   <= 8'h00;
      addr_r   <= 16'h0000;
      type_r   <= 8'h00;
      sum_r    <= 8'h00;
      offset_r <= 8'h00;
      wptr_r   <= 1'b0;
      rptr_r   <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      left_r   <= left_nxt;
      addr_r   <= addr_nxt;
      type_r   <= type_nxt;
      sum_r    <= sum_nxt;
      offset_r <= offset_nxt;
      if (res_push) begin
        wptr_r <= !wptr_r;
      end
      if (do_res_pop) begin
        rptr_r <= !rptr_r;
      end
      count_r <= count_r + {1'b0, res_push} - {1'b0, do_res_pop};
    end
  end

endmodule

// ===== design/intel_hex_record_parser.sv =====
// Intel HEX record parser, top level.
// Takes one character per cycle while in_full is low; the character that completes a
// result passes front decode, event queue, back end and result queue, both queues registered.
// Sustained rate is one character per cycle while results are popped.
// Synchronous active-low reset empties both queues and returns to waiting for ':'.
module intel_hex_record_parser import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_in,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_address,
  output logic [7:0]  out_record_type,
  output logic [7:0]  out_byte_index,
  output logic [7:0]  out_byte_count,
  output logic [7:0]  out_checksum_value,
  output logic        out_checksum_ok
);

  logic ev_push, ev_empty, ev_pop, evq_full;
  ev_t  ev_in, ev_head;
  res_t res;

  assign in_full = evq_full;

  ihex_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_push && !evq_full),
    .in_char   (in_char_in),
    .ev_push   (ev_push),
    .ev        (ev_in)
  );

  ihex_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ev_push),
    .push_ev (ev_in),
    .full    (evq_full),
    .pop     (ev_pop),
    .empty   (ev_empty),
    .head    (ev_head)
  );

  ihex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_empty  (ev_empty),
    .ev        (ev_head),
    .ev_pop    (ev_pop),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .res       (res)
  );

  assign out_kind           = res.kind;
  assign out_data_byte      = res.data_byte;
  assign out_address        = res.address;
  assign out_record_type    = res.record_type;
  assign out_byte_index     = res.byte_index;
  assign out_byte_count     = res.byte_count;
  assign out_checksum_value = res.checksum_value;
  assign out_checksum_ok    = res.checksum_ok;

endmodule

// ===== design/ihex_checker.sv =====
// Port-level checker for the Intel HEX record parser, bound to the top level.
// Depends on intel_hex_record_parser_macros.svh and ihex_pkg.
`include "intel_hex_record_parser_macros.svh"
module ihex_checker import ihex_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic        out_kind,
  input logic [7:0]  out_data_byte,
  input logic [15:0] out_address,
  input logic [7:0]  out_record_type,
  input logic [7:0]  out_byte_index,
  input logic [7:0]  out_byte_count,
  input logic [7:0]  out_checksum_value,
  input logic        out_checksum_ok
);

  logic        end_shown, data_shown;
  logic [57:0] head_bits;

  assign end_shown  = !out_empty && (out_kind == KIND_END);
  assign data_shown = !out_empty && (out_kind == KIND_DATA);
  assign head_bits  = {out_kind, out_data_byte, out_address, out_record_type,
                       out_byte_index, out_byte_count, out_checksum_value,
                       out_checksum_ok};

  `IHEX_ASSERT_RST(a_reset_clears, !rst_n |=> (out_empty && !in_full))
  `IHEX_ASSERT(a_end_fields, end_shown |-> (out_data_byte == 8'h00 && out_byte_index == 8'h00))
  `IHEX_ASSERT(a_data_fields, data_shown |-> (out_checksum_value == 8'h00 && !out_checksum_ok))
  `IHEX_ASSERT(a_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(head_bits)))

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);
